/* rtl/core/emsc_pkg.sv */
// Shared types and constants for the extent map share comparator.
// No dependencies; imported by every other file in rtl/core but emsc_rsp_if and emsc_queue.
package emsc_pkg;

   // Fixed field widths of the channel payloads and the register port.
   localparam int unsigned FIELD_BITS     = 64;
   localparam int unsigned FLAG_BITS      = 32;
   localparam int unsigned CSR_INDEX_BITS = 2;

   // Unknown, delayed and inline extent flags.
   localparam logic [FLAG_BITS-1:0] NO_ADDRESS_MASK_RESET = 32'd518;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TARGET_OFFSET   = 2'd0,
      CSR_DEST_OFFSET     = 2'd1,
      CSR_RANGE_LENGTH    = 2'd2,
      CSR_NO_ADDRESS_MASK = 2'd3
   } emsc_csr_type;

   // Position-independent facts about one record pair, worked out by the front end.
   // kt/kd: record start minus range offset (range coordinates).
   // ktm:   kt plus the shorter record length.
   // ft/fd: record end in range coordinates.
   typedef struct packed {
      logic first;
      logic tgt_present;
      logic dest_present;
      logic len_zero;
      logic no_address;
      logic phys_equal;
      logic len_differ;
      logic kt_eq_kd;
      logic kt_eq_len;
      logic kd_eq_len;
      logic kt_ge_len;
      logic ktm_ge_len;
      logic ft_ge_len;
      logic fd_ge_len;
      logic ft_ne_fd;
   } emsc_cond_type;

endpackage

/* rtl/core/emsc_req_if.sv */
// Request channel of the extent map share comparator: one record pair per transaction.
// Depends on emsc_pkg for the field widths.
interface emsc_req_if;
   import emsc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  first;
   logic                  tgt_present;
   logic [FIELD_BITS-1:0] tgt_logical;
   logic [FIELD_BITS-1:0] tgt_physical;
   logic [FIELD_BITS-1:0] tgt_length;
   logic [FLAG_BITS-1:0]  tgt_flags;
   logic                  dest_present;
   logic [FIELD_BITS-1:0] dest_logical;
   logic [FIELD_BITS-1:0] dest_physical;
   logic [FIELD_BITS-1:0] dest_length;
   logic [FLAG_BITS-1:0]  dest_flags;

   modport source (
      output valid, first, tgt_present, tgt_logical, tgt_physical, tgt_length, tgt_flags,
      output dest_present, dest_logical, dest_physical, dest_length, dest_flags,
      input  ready
   );

   modport sink (
      input  valid, first, tgt_present, tgt_logical, tgt_physical, tgt_length, tgt_flags,
      input  dest_present, dest_logical, dest_physical, dest_length, dest_flags,
      output ready
   );

endinterface

/* rtl/core/emsc_rsp_if.sv */
// Response channel of the extent map share comparator: one decision per transaction.
// No package dependency.
interface emsc_rsp_if;

   logic valid;
   logic ready;
   logic done_res;
   logic shared;

   modport source (output valid, done_res, shared, input ready);
   modport sink (input valid, done_res, shared, output ready);

endinterface

/* rtl/core/emsc_csr.sv */
// Configuration registers of the extent map share comparator.
// Depends on emsc_pkg for register indexes and widths.
module emsc_csr #(
   parameter int unsigned OFFSET_BITS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [emsc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [emsc_pkg::FIELD_BITS-1:0]      csr_wdata,
   output logic [OFFSET_BITS-1:0]               target_offset,
   output logic [OFFSET_BITS-1:0]               dest_offset,
   output logic [OFFSET_BITS-1:0]               range_length,
   output logic [emsc_pkg::FLAG_BITS-1:0]       no_address_mask
);
   import emsc_pkg::*;

   logic [OFFSET_BITS-1:0] target_offset_ff;
   logic [OFFSET_BITS-1:0] dest_offset_ff;
   logic [OFFSET_BITS-1:0] range_length_ff;
   logic [FLAG_BITS-1:0]   no_address_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_offset_ff   <= '0;
         dest_offset_ff     <= '0;
         range_length_ff    <= '0;
         no_address_mask_ff <= NO_ADDRESS_MASK_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_OFFSET:   target_offset_ff   <= csr_wdata[OFFSET_BITS-1:0];
            CSR_DEST_OFFSET:     dest_offset_ff     <= csr_wdata[OFFSET_BITS-1:0];
            CSR_RANGE_LENGTH:    range_length_ff    <= csr_wdata[OFFSET_BITS-1:0];
            CSR_NO_ADDRESS_MASK: no_address_mask_ff <= csr_wdata[FLAG_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign target_offset   = target_offset_ff;
   assign dest_offset     = dest_offset_ff;
   assign range_length    = range_length_ff;
   assign no_address_mask = no_address_mask_ff;

endmodule

/* rtl/core/emsc_front.sv */
// Front end: accepts record pairs and reduces them to position-independent facts.
// Two register stages; depends on emsc_pkg and emsc_req_if.
module emsc_front #(
   parameter int unsigned OFFSET_BITS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   emsc_req_if.sink                        req_if,
   input  logic [OFFSET_BITS-1:0]          target_offset,
   input  logic [OFFSET_BITS-1:0]          dest_offset,
   input  logic [OFFSET_BITS-1:0]          range_length,
   input  logic [emsc_pkg::FLAG_BITS-1:0]  no_address_mask,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [OFFSET_BITS-1:0]          out_tl,
   output logic [OFFSET_BITS-1:0]          out_dl,
   output logic [OFFSET_BITS-1:0]          out_kt,
   output logic [OFFSET_BITS-1:0]          out_ktm,
   output logic [OFFSET_BITS-1:0]          out_ft,
   output logic [OFFSET_BITS-1:0]          out_fd,
   output emsc_pkg::emsc_cond_type         out_cond
);
   import emsc_pkg::*;

   // stage A
   logic                   a_vld_ff;
   logic                   a_first_ff, a_tp_ff, a_dp_ff;
   logic                   a_noaddr_ff, a_phys_eq_ff, a_len_zero_ff, a_len_differ_ff;
   logic [OFFSET_BITS-1:0] a_tl_ff, a_dl_ff, a_tlen_ff, a_dlen_ff;
   logic [OFFSET_BITS-1:0] a_kt_ff, a_kd_ff, a_min_ff;
   logic [OFFSET_BITS-1:0] tl, dl, tlen, dlen;
   logic [OFFSET_BITS-1:0] a_kt_in, a_kd_in, a_min_in;
   logic                   a_noaddr_in, a_phys_eq_in;

   // stage B
   logic                   b_vld_ff;
   logic [OFFSET_BITS-1:0] b_tl_ff, b_dl_ff, b_kt_ff, b_ktm_ff, b_ft_ff, b_fd_ff;
   emsc_cond_type          b_cond_ff;
   logic [OFFSET_BITS-1:0] b_ktm_in, b_ft_in, b_fd_in;
   emsc_cond_type          b_cond_in;

   logic a_adv, b_adv;

   // advance a stage when it is empty or its content moves on; hold off input in reset
   assign b_adv        = !b_vld_ff || out_ready;
   assign a_adv        = !a_vld_ff || b_adv;
   assign req_if.ready = a_adv && !reset;

   assign tl   = req_if.tgt_logical[OFFSET_BITS-1:0];
   assign dl   = req_if.dest_logical[OFFSET_BITS-1:0];
   assign tlen = req_if.tgt_length[OFFSET_BITS-1:0];
   assign dlen = req_if.dest_length[OFFSET_BITS-1:0];

   always_comb begin
      a_kt_in      = tl - target_offset;
      a_kd_in      = dl - dest_offset;
      a_min_in     = (tlen < dlen) ? tlen : dlen;
      a_noaddr_in  = |((req_if.tgt_flags | req_if.dest_flags) & no_address_mask);
      a_phys_eq_in = req_if.tgt_physical[OFFSET_BITS-1:0] ==
                     req_if.dest_physical[OFFSET_BITS-1:0];
   end

   always_comb begin
      b_ktm_in = a_kt_ff + a_min_ff;
      b_ft_in  = a_kt_ff + a_tlen_ff;
      b_fd_in  = a_kd_ff + a_dlen_ff;

      b_cond_in.first        = a_first_ff;
      b_cond_in.tgt_present  = a_tp_ff;
      b_cond_in.dest_present = a_dp_ff;
      b_cond_in.len_zero     = a_len_zero_ff;
      b_cond_in.no_address   = a_noaddr_ff;
      b_cond_in.phys_equal   = a_phys_eq_ff;
      b_cond_in.len_differ   = a_len_differ_ff;
      b_cond_in.kt_eq_kd     = a_kt_ff == a_kd_ff;
      b_cond_in.kt_eq_len    = a_kt_ff == range_length;
      b_cond_in.kd_eq_len    = a_kd_ff == range_length;
      b_cond_in.kt_ge_len    = a_kt_ff >= range_length;
      b_cond_in.ktm_ge_len   = b_ktm_in >= range_length;
      b_cond_in.ft_ge_len    = b_ft_in >= range_length;
      b_cond_in.fd_ge_len    = b_fd_in >= range_length;
      b_cond_in.ft_ne_fd     = b_ft_in != b_fd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         if (a_adv) a_vld_ff <= req_if.valid;
         if (b_adv) b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         a_first_ff      <= req_if.first;
         a_tp_ff         <= req_if.tgt_present;
         a_dp_ff         <= req_if.dest_present;
         a_tl_ff         <= tl;
         a_dl_ff         <= dl;
         a_tlen_ff       <= tlen;
         a_dlen_ff       <= dlen;
         a_kt_ff         <= a_kt_in;
         a_kd_ff         <= a_kd_in;
         a_min_ff        <= a_min_in;
         a_noaddr_ff     <= a_noaddr_in;
         a_phys_eq_ff    <= a_phys_eq_in;
         a_len_zero_ff   <= range_length == '0;
         a_len_differ_ff <= tlen != dlen;
      end
      if (b_adv) begin
         b_tl_ff   <= a_tl_ff;
         b_dl_ff   <= a_dl_ff;
         b_kt_ff   <= a_kt_ff;
         b_ktm_ff  <= b_ktm_in;
         b_ft_ff   <= b_ft_in;
         b_fd_ff   <= b_fd_in;
         b_cond_ff <= b_cond_in;
      end
   end

   assign out_valid = b_vld_ff;
   assign out_tl    = b_tl_ff;
   assign out_dl    = b_dl_ff;
   assign out_kt    = b_kt_ff;
   assign out_ktm   = b_ktm_ff;
   assign out_ft    = b_ft_ff;
   assign out_fd    = b_fd_ff;
   assign out_cond  = b_cond_ff;

endmodule

/* rtl/core/emsc_queue.sv */
// Two-entry queue between the front end and the back end.
// No package dependency; payload is a flat vector.
module emsc_queue #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int unsigned DEPTH    = 2;
   localparam int unsigned PTR_BITS = $clog2(DEPTH);
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                push, pop;

   assign in_ready  = count_ff != CNT_BITS'(DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         if (push && !pop)      count_ff <= count_ff + CNT_BITS'(1);
         else if (pop && !push) count_ff <= count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

endmodule

/* rtl/core/emsc_back.sv */
// Back end: walks the covered count over record pairs and registers the decision.
// Depends on emsc_pkg and emsc_rsp_if.
module emsc_back #(
   parameter int unsigned OFFSET_BITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [OFFSET_BITS-1:0]  in_tl,
   input  logic [OFFSET_BITS-1:0]  in_dl,
   input  logic [OFFSET_BITS-1:0]  in_kt,
   input  logic [OFFSET_BITS-1:0]  in_ktm,
   input  logic [OFFSET_BITS-1:0]  in_ft,
   input  logic [OFFSET_BITS-1:0]  in_fd,
   input  emsc_pkg::emsc_cond_type in_cond,
   input  logic [OFFSET_BITS-1:0]  target_offset,
   input  logic [OFFSET_BITS-1:0]  dest_offset,
   input  logic [OFFSET_BITS-1:0]  range_length,
   emsc_rsp_if.source              rsp_if
);
   import emsc_pkg::*;

   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic                   decided_ff, decided_in;
   logic                   verdict_ff, verdict_in;
   logic                   rsp_vld_ff, done_ff, shared_ff;

   logic [OFFSET_BITS-1:0] pos, ta, da, ra, rb;
   logic                   th, dh, rest_zero, ra_lt;
   logic                   holes_eq, hole_nz, reach_ge;
   logic                   pop;

   assign in_ready = !rsp_vld_ff || rsp_if.ready;
   assign pop      = in_valid && in_ready;

   always_comb begin
      pos        = in_cond.first ? '0 : pos_ff;
      pos_in     = pos;
      decided_in = decided_ff;
      verdict_in = verdict_ff;
      if (in_cond.first) begin
         decided_in = in_cond.len_zero || !in_cond.tgt_present;
         verdict_in = 1'b0;
      end

      ta        = target_offset + pos;
      da        = dest_offset + pos;
      th        = in_cond.tgt_present && (in_tl > ta);
      dh        = in_cond.dest_present && (in_dl > da);
      rest_zero = pos == range_length;
      ra        = in_ft - pos;
      rb        = in_fd - pos;
      ra_lt     = ra < rb;
      reach_ge  = ra_lt ? in_cond.ft_ge_len : in_cond.fd_ge_len;

      // compare the holes in front of both records
      if (in_cond.tgt_present && in_cond.dest_present) begin
         holes_eq = th ? (dh && in_cond.kt_eq_kd) : !dh;
         hole_nz  = th;
      end else if (in_cond.tgt_present) begin
         holes_eq = th ? in_cond.kt_eq_len : rest_zero;
         hole_nz  = !rest_zero;
      end else if (in_cond.dest_present) begin
         holes_eq = dh ? in_cond.kd_eq_len : rest_zero;
         hole_nz  = !rest_zero;
      end else begin
         holes_eq = 1'b1;
         hole_nz  = !rest_zero;
      end

      if (!decided_in) begin
         // skip a common hole
         if (!holes_eq) begin
            decided_in = 1'b1;
            verdict_in = 1'b0;
         end else if (hole_nz) begin
            if (in_cond.tgt_present && in_cond.dest_present) begin
               pos_in = in_kt;
               if (in_cond.kt_ge_len) begin
                  decided_in = 1'b1;
                  verdict_in = 1'b1;
               end
            end else begin
               // hole runs to the end of the range
               pos_in     = range_length;
               decided_in = 1'b1;
               verdict_in = 1'b1;
            end
         end

         // match the records themselves
         if (!decided_in) begin
            if (!in_cond.tgt_present || !in_cond.dest_present || in_cond.no_address) begin
               decided_in = 1'b1;
               verdict_in = 1'b0;
            end else if (hole_nz) begin
               // both records start right here: offsets into them are zero
               if (!in_cond.phys_equal) begin
                  decided_in = 1'b1;
                  verdict_in = 1'b0;
               end else begin
                  pos_in = in_ktm;
                  if (in_cond.len_differ && !in_cond.ktm_ge_len) begin
                     decided_in = 1'b1;
                     verdict_in = 1'b0;
                  end else if (in_cond.ktm_ge_len) begin
                     decided_in = 1'b1;
                     verdict_in = 1'b1;
                  end
               end
            end else begin
               if (!in_cond.kt_eq_kd || !in_cond.phys_equal) begin
                  decided_in = 1'b1;
                  verdict_in = 1'b0;
               end else begin
                  pos_in = ra_lt ? in_ft : in_fd;
                  if (in_cond.ft_ne_fd && !reach_ge) begin
                     decided_in = 1'b1;
                     verdict_in = 1'b0;
                  end else if (reach_ge) begin
                     decided_in = 1'b1;
                     verdict_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
         pos_ff     <= '0;
         decided_ff <= 1'b1;
         verdict_ff <= 1'b0;
      end else begin
         if (in_ready) rsp_vld_ff <= in_valid;
         if (pop) begin
            pos_ff     <= pos_in;
            decided_ff <= decided_in;
            verdict_ff <= verdict_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         done_ff   <= decided_in;
         shared_ff <= decided_in && verdict_in;
      end
   end

   assign rsp_if.valid    = rsp_vld_ff;
   assign rsp_if.done_res = done_ff;
   assign rsp_if.shared   = shared_ff;

endmodule

/* rtl/core/extent_map_share_comparator.sv */
// Top level of the extent map share comparator: registers, front end, queue, back end.
// Depends on emsc_pkg, emsc_req_if, emsc_rsp_if, emsc_csr, emsc_front, emsc_queue, emsc_back.

// Decides whether a byte range of a target file and of a destination file sit on the
// same stored extents. Each request transaction carries record i of both extent maps
// (either may be absent); each one gets exactly one response with done_res and shared.
// A transaction with first set restarts the comparison; after the decision, further
// transactions leave the state alone and echo the decision. Throughput is one
// transaction per clock while rsp_if.ready is high: the covered-byte count in the
// back end is the only loop, and it closes combinationally through a few wide adds,
// compares and a select. An accepted transaction passes through the two front-end
// stages, the queue and the response register before its response is valid. The
// queue holds two entries, so front and back stall independently. No request is taken
// while reset is high. Registers are written through csr_we/csr_index/csr_wdata and
// must only change while no transaction is in flight. No clearing pass follows reset.
module extent_map_share_comparator #(
   parameter int unsigned OFFSET_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   emsc_req_if.sink                            req_if,
   emsc_rsp_if.source                          rsp_if,
   input  logic                                csr_we,
   input  logic [emsc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [emsc_pkg::FIELD_BITS-1:0]     csr_wdata
);
   import emsc_pkg::*;

   // queue entry: decision flags plus six OFFSET_BITS-wide values
   localparam int unsigned ENTRY_BITS = $bits(emsc_cond_type) + 6 * OFFSET_BITS;

   logic [OFFSET_BITS-1:0] target_offset, dest_offset, range_length;
   logic [FLAG_BITS-1:0]   no_address_mask;

   // front end to queue
   logic                   f_valid, f_ready;
   logic [OFFSET_BITS-1:0] f_tl, f_dl, f_kt, f_ktm, f_ft, f_fd;
   emsc_cond_type          f_cond;

   // queue to back end
   logic                   b_valid, b_ready;
   logic [OFFSET_BITS-1:0] b_tl, b_dl, b_kt, b_ktm, b_ft, b_fd;
   emsc_cond_type          b_cond;

   logic [ENTRY_BITS-1:0]  q_in_data, q_out_data;

   emsc_csr #(.OFFSET_BITS(OFFSET_BITS)) u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .target_offset   (target_offset),
      .dest_offset     (dest_offset),
      .range_length    (range_length),
      .no_address_mask (no_address_mask)
   );

   // Classify each record pair without the running position.
   emsc_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_if),
      .target_offset   (target_offset),
      .dest_offset     (dest_offset),
      .range_length    (range_length),
      .no_address_mask (no_address_mask),
      .out_valid       (f_valid),
      .out_ready       (f_ready),
      .out_tl          (f_tl),
      .out_dl          (f_dl),
      .out_kt          (f_kt),
      .out_ktm         (f_ktm),
      .out_ft          (f_ft),
      .out_fd          (f_fd),
      .out_cond        (f_cond)
   );

   // Pack and unpack the queue entry.
   assign q_in_data = {f_cond, f_tl, f_dl, f_kt, f_ktm, f_ft, f_fd};
   assign {b_cond, b_tl, b_dl, b_kt, b_ktm, b_ft, b_fd} = q_out_data;

   emsc_queue #(.WIDTH(ENTRY_BITS)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (q_in_data),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (q_out_data)
   );

   // Advance the covered count and produce one response per transaction.
   emsc_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (b_valid),
      .in_ready      (b_ready),
      .in_tl         (b_tl),
      .in_dl         (b_dl),
      .in_kt         (b_kt),
      .in_ktm        (b_ktm),
      .in_ft         (b_ft),
      .in_fd         (b_fd),
      .in_cond       (b_cond),
      .target_offset (target_offset),
      .dest_offset   (dest_offset),
      .range_length  (range_length),
      .rsp_if        (rsp_if)
   );

endmodule

/* verif/extent_map_share_comparator_tb.sv */
// Self-checking testbench for extent_map_share_comparator: directed and random record pairs.
// Depends on emsc_pkg, emsc_req_if, emsc_rsp_if and the RTL under rtl/core.
module extent_map_share_comparator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import emsc_pkg::*;

   typedef struct {
      logic                  first;
      logic                  tgt_present;
      logic [FIELD_BITS-1:0] tgt_logical;
      logic [FIELD_BITS-1:0] tgt_physical;
      logic [FIELD_BITS-1:0] tgt_length;
      logic [FLAG_BITS-1:0]  tgt_flags;
      logic                  dest_present;
      logic [FIELD_BITS-1:0] dest_logical;
      logic [FIELD_BITS-1:0] dest_physical;
      logic [FIELD_BITS-1:0] dest_length;
      logic [FLAG_BITS-1:0]  dest_flags;
   } extent_pair_type;

   typedef struct {
      logic done_res;
      logic shared;
   } share_decision_type;

   localparam logic [FIELD_BITS-1:0] ALL_ONES = '1;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [FIELD_BITS-1:0]     csr_wdata;

   emsc_req_if req_bus ();
   emsc_rsp_if rsp_bus ();

   extent_map_share_comparator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the registers, written together with the CSR port.
   logic [FIELD_BITS-1:0] cfg_toff = '0;
   logic [FIELD_BITS-1:0] cfg_doff = '0;
   logic [FIELD_BITS-1:0] cfg_len  = '0;
   logic [FLAG_BITS-1:0]  cfg_mask = NO_ADDRESS_MASK_RESET;

   // Comparison progress as the block should hold it. Idle and decided out of reset.
   logic [FIELD_BITS-1:0] cmp_covered = '0;
   logic                  cmp_decided = 1'b1;
   logic                  cmp_verdict = 1'b0;

   extent_pair_type    pending_pairs[$];
   share_decision_type expected_decisions[$];

   int   mismatch_count = 0;
   logic req_taken      = 1'b0;
   logic steady_phase   = 1'b0;
   int   req_gap        = 0;
   int   rsp_stall      = 0;

   // -------------------------------------------------------------------------
   // Clock and time limit
   // -------------------------------------------------------------------------
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bound the run well beyond the slowest legal pace: every transaction waiting out
   // the longest source gap plus the longest sink stall plus the pipeline latency.
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Helpers
   // -------------------------------------------------------------------------
   task automatic report_mismatch(string msg);
      if (mismatch_count < 100) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic logic [FIELD_BITS-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [FIELD_BITS-1:0] rand_below(logic [FIELD_BITS-1:0] n);
      if (n == 0) return '0;
      return rand64() % n;
   endfunction

   // Unallocated bytes ahead of a record at position at; the whole rest if absent.
   function automatic logic [FIELD_BITS-1:0] hole_ahead(logic present,
                                                        logic [FIELD_BITS-1:0] logical,
                                                        logic [FIELD_BITS-1:0] at,
                                                        logic [FIELD_BITS-1:0] rest);
      if (!present) return rest;
      return (logical > at) ? logical - at : '0;
   endfunction

   function automatic void conclude(logic v);
      cmp_decided = 1'b1;
      cmp_verdict = v;
   endfunction

   // Advance the comparison by one record pair and return the decision it leaves.
   function automatic share_decision_type predict_share(extent_pair_type r);
      logic [FIELD_BITS-1:0] pos, rest, ta, da, ha, hb, pa, pb, ra, rb;
      share_decision_type d;
      if (r.first) begin
         cmp_covered = '0;
         cmp_decided = 1'b0;
         cmp_verdict = 1'b0;
         // Empty range or empty target map: not shared at once.
         if (cfg_len == 0 || !r.tgt_present) conclude(1'b0);
      end
      if (!cmp_decided) begin
         pos  = cmp_covered;
         rest = cfg_len - pos;
         ta   = cfg_toff + pos;
         da   = cfg_doff + pos;
         ha   = hole_ahead(r.tgt_present, r.tgt_logical, ta, rest);
         hb   = hole_ahead(r.dest_present, r.dest_logical, da, rest);
         // Skip a common hole; a hole on one side only breaks sharing.
         if (ha != hb) begin
            conclude(1'b0);
         end else if (ha != 0) begin
            pos = pos + ha;
            ta  = cfg_toff + pos;
            da  = cfg_doff + pos;
            if (pos >= cfg_len) conclude(1'b1);
         end
         if (!cmp_decided) begin
            if (!r.tgt_present || !r.dest_present) begin
               conclude(1'b0);
            end else if (((r.tgt_flags | r.dest_flags) & cfg_mask) != 0) begin
               conclude(1'b0);
            end else begin
               pa = ta - r.tgt_logical;
               pb = da - r.dest_logical;
               if (pa != pb || r.tgt_physical != r.dest_physical) begin
                  conclude(1'b0);
               end else begin
                  ra  = r.tgt_length - pa;
                  rb  = r.dest_length - pb;
                  pos = pos + ((ra < rb) ? ra : rb);
                  // Uneven remainders pass only when they finish the range.
                  if (ra != rb && pos < cfg_len) conclude(1'b0);
                  else if (pos >= cfg_len) conclude(1'b1);
               end
            end
         end
         cmp_covered = pos;
      end
      d.done_res = cmp_decided;
      d.shared   = cmp_decided & cmp_verdict;
      return d;
   endfunction

   task automatic push_pair(logic first, logic tp, logic [FIELD_BITS-1:0] tl,
                            logic [FIELD_BITS-1:0] tphys, logic [FIELD_BITS-1:0] tlen,
                            logic [FLAG_BITS-1:0] tf, logic dp, logic [FIELD_BITS-1:0] dl,
                            logic [FIELD_BITS-1:0] dphys, logic [FIELD_BITS-1:0] dlen,
                            logic [FLAG_BITS-1:0] df);
      extent_pair_type r;
      r.first        = first;
      r.tgt_present  = tp;
      r.tgt_logical  = tl;
      r.tgt_physical = tphys;
      r.tgt_length   = tlen;
      r.tgt_flags    = tf;
      r.dest_present = dp;
      r.dest_logical = dl;
      r.dest_physical = dphys;
      r.dest_length  = dlen;
      r.dest_flags   = df;
      pending_pairs.push_back(r);
   endtask

   function automatic extent_pair_type noise_pair(logic first);
      extent_pair_type r;
      r.first         = first;
      r.tgt_present   = $urandom_range(0, 1);
      r.tgt_logical   = rand64();
      r.tgt_physical  = rand64();
      r.tgt_length    = rand64();
      r.tgt_flags     = $urandom;
      r.dest_present  = $urandom_range(0, 1);
      r.dest_logical  = rand64();
      r.dest_physical = rand64();
      r.dest_length   = rand64();
      r.dest_flags    = $urandom;
      return r;
   endfunction

   // Queue one well-formed comparison (records tiling the range, with common holes,
   // zero remainders and ragged ends), optionally broken in one record.
   // Return the number of transactions queued.
   function automatic int queue_comparison();
      logic [FIELD_BITS-1:0] pos, rest, h, a, seg, ta, da;
      extent_pair_type r;
      int k, j, bad;
      k   = $urandom_range(1, 6);
      bad = ($urandom_range(0, 2) == 0) ? $urandom_range(0, k - 1) : -1;
      pos = '0;
      for (j = 0; j < k; j++) begin
         rest = cfg_len - pos;
         r = noise_pair(j == 0);
         r.tgt_present  = 1'b1;
         r.dest_present = 1'b1;
         r.tgt_flags    = $urandom & ~cfg_mask;
         r.dest_flags   = $urandom & ~cfg_mask;
         h = ($urandom_range(0, 3) == 0 && rest > 1) ? rand_below(rest) : '0;
         a = (h == 0 && $urandom_range(0, 1) == 1) ? rand_below(64'h1_0000) : '0;
         if (j == k - 1)
            seg = rest - h + (($urandom_range(0, 1) == 1) ? rand_below(1000) : '0);
         else
            seg = (rest - h > 1) ? rand_below(rest - h) : '0;
         ta = cfg_toff + pos + h;
         da = cfg_doff + pos + h;
         r.tgt_logical   = ta - a;
         r.dest_logical  = da - a;
         r.dest_physical = r.tgt_physical;
         r.tgt_length    = a + seg;
         r.dest_length   = a + seg;
         if (j == k - 1 && $urandom_range(0, 2) == 0)
            r.dest_length = r.dest_length + rand_below(1000) + 1;
         // End some maps early: both absent, or one side a hole to the end.
         if (j == k - 1 && $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  r.tgt_present  = 1'b0;
                  r.dest_present = 1'b0;
               end
               1: begin
                  r.tgt_present  = 1'b0;
                  r.dest_logical = cfg_doff + pos + rest + $urandom_range(0, 1);
               end
               default: begin
                  r.dest_present = 1'b0;
                  r.tgt_logical  = cfg_toff + pos + rest + $urandom_range(0, 1);
               end
            endcase
         end
         if (j == bad) begin
            case ($urandom_range(0, 7))
               0: r.tgt_physical[$urandom_range(0, 63)] ^= 1'b1;
               1: r.dest_logical[$urandom_range(0, 63)] ^= 1'b1;
               2: r.tgt_length[$urandom_range(0, 63)] ^= 1'b1;
               3: r.tgt_flags[$urandom_range(0, 31)] = 1'b1;
               4: r.dest_flags = $urandom;
               5: r.tgt_present = 1'b0;
               6: r.dest_present = 1'b0;
               default: r.first = 1'b1;
            endcase
         end
         pending_pairs.push_back(r);
         pos = pos + h + seg;
      end
      return k;
   endfunction

   // Write all four registers back to back, one per falling edge.
   task automatic write_config(logic [FIELD_BITS-1:0] toff, logic [FIELD_BITS-1:0] doff,
                               logic [FIELD_BITS-1:0] len, logic [FLAG_BITS-1:0] mask);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_TARGET_OFFSET;
      csr_wdata <= toff;
      @(negedge clock);
      csr_index <= CSR_DEST_OFFSET;
      csr_wdata <= doff;
      @(negedge clock);
      csr_index <= CSR_RANGE_LENGTH;
      csr_wdata <= len;
      @(negedge clock);
      csr_index <= CSR_NO_ADDRESS_MASK;
      // Upper bits are don't-care for the mask; toggle them anyway.
      csr_wdata <= {$urandom, mask};
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_toff = toff;
      cfg_doff = doff;
      cfg_len  = len;
      cfg_mask = mask;
   endtask

   // Hold until every queued transaction is accepted and answered, then let the
   // pipeline settle.
   task automatic drain_pipeline();
      while (pending_pairs.size() != 0 || req_bus.valid || expected_decisions.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Request driver: advance at the falling edge once the held transaction is taken.
   // Idle bursts start only when no transaction is held, so valid never retracts.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      extent_pair_type r;
      if (!req_bus.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (!steady_phase && $urandom_range(0, 15) == 0) begin
            req_gap = $urandom_range(0, 17);
            req_bus.valid <= 1'b0;
         end else if (pending_pairs.size() != 0) begin
            r = pending_pairs.pop_front();
            req_bus.first         <= r.first;
            req_bus.tgt_present   <= r.tgt_present;
            req_bus.tgt_logical   <= r.tgt_logical;
            req_bus.tgt_physical  <= r.tgt_physical;
            req_bus.tgt_length    <= r.tgt_length;
            req_bus.tgt_flags     <= r.tgt_flags;
            req_bus.dest_present  <= r.dest_present;
            req_bus.dest_logical  <= r.dest_logical;
            req_bus.dest_physical <= r.dest_physical;
            req_bus.dest_length   <= r.dest_length;
            req_bus.dest_flags    <= r.dest_flags;
            req_bus.valid         <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response back-pressure: random stall bursts.
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_bus.ready <= 1'b0;
      end else if (!steady_phase && $urandom_range(0, 15) == 0) begin
         rsp_stall = $urandom_range(0, 17);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: predict on every accepted request, check every accepted response.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      extent_pair_type    seen;
      share_decision_type want;
      req_taken <= req_bus.valid && req_bus.ready;
      if (req_bus.valid && req_bus.ready) begin
         seen.first         = req_bus.first;
         seen.tgt_present   = req_bus.tgt_present;
         seen.tgt_logical   = req_bus.tgt_logical;
         seen.tgt_physical  = req_bus.tgt_physical;
         seen.tgt_length    = req_bus.tgt_length;
         seen.tgt_flags     = req_bus.tgt_flags;
         seen.dest_present  = req_bus.dest_present;
         seen.dest_logical  = req_bus.dest_logical;
         seen.dest_physical = req_bus.dest_physical;
         seen.dest_length   = req_bus.dest_length;
         seen.dest_flags    = req_bus.dest_flags;
         expected_decisions.push_back(predict_share(seen));
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
         if (expected_decisions.size() == 0) begin
            report_mismatch("response with no transaction outstanding");
         end else begin
            want = expected_decisions.pop_front();
            if (rsp_bus.done_res !== want.done_res)
               report_mismatch($sformatf("done_res got %b want %b",
                                         rsp_bus.done_res, want.done_res));
            if (rsp_bus.shared !== want.shared)
               report_mismatch($sformatf("shared got %b want %b",
                                         rsp_bus.shared, want.shared));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [FIELD_BITS-1:0] t0, d0;
      int p, count, quota;

      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = CSR_TARGET_OFFSET;
      csr_wdata             = '0;
      req_bus.valid         = 1'b0;
      req_bus.first         = 1'b0;
      req_bus.tgt_present   = 1'b0;
      req_bus.tgt_logical   = '0;
      req_bus.tgt_physical  = '0;
      req_bus.tgt_length    = '0;
      req_bus.tgt_flags     = '0;
      req_bus.dest_present  = 1'b0;
      req_bus.dest_logical  = '0;
      req_bus.dest_physical = '0;
      req_bus.dest_length   = '0;
      req_bus.dest_flags    = '0;
      rsp_bus.ready         = 1'b0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset registers: before any first transaction the block answers done, not
      // shared; then a first transaction with a zero-length range is not shared.
      push_pair(0, 1, 0, 0, 100, 0, 1, 0, 0, 100, 0);
      push_pair(1, 1, 0, 0, 100, 0, 1, 0, 0, 100, 0);
      drain_pipeline();

      // Directed cases on a 100-byte range.
      write_config(64'd1000, 64'd5000, 64'd100, NO_ADDRESS_MASK_RESET);
      t0 = 64'd1000;
      d0 = 64'd5000;
      // one shared extent covering the range, then an echo after the decision
      push_pair(1, 1, t0, 64'h4000, 100, 0, 1, d0, 64'h4000, 100, 0);
      push_pair(0, 1, ALL_ONES, ALL_ONES, ALL_ONES, '1, 1, ALL_ONES, ALL_ONES, ALL_ONES, '1);
      // empty target map
      push_pair(1, 0, t0, 64'h4000, 100, 0, 1, d0, 64'h4000, 100, 0);
      // record starting before the range, then a common hole leading to the rest
      push_pair(1, 1, t0 - 8, 64'h7000, 48, 0, 1, d0 - 8, 64'h7000, 48, 0);
      push_pair(0, 1, t0 + 60, 64'h9000, 40, 0, 1, d0 + 60, 64'h9000, 40, 0);
      // holes of different size
      push_pair(1, 1, t0 + 10, 64'h4000, 90, 0, 1, d0 + 20, 64'h4000, 80, 0);
      // zero remainder, then both records absent
      push_pair(1, 1, t0, 64'h4000, 0, 0, 1, d0, 64'h4000, 0, 0);
      push_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      // target absent, destination hole equal to the rest
      push_pair(1, 1, t0, 64'h4000, 50, 0, 1, d0, 64'h4000, 50, 0);
      push_pair(0, 0, 0, 0, 0, 0, 1, d0 + 100, 64'h5000, 10, 0);
      // destination absent, target hole shorter than the rest
      push_pair(1, 1, t0, 64'h4000, 50, 0, 1, d0, 64'h4000, 50, 0);
      push_pair(0, 1, t0 + 90, 64'h5000, 10, 0, 0, 0, 0, 0, 0);
      // common hole reaching past the range
      push_pair(1, 1, t0 + 200, 64'h4000, 10, 0, 1, d0 + 200, 64'h4000, 10, 0);
      // no-address flag, physical start mismatch, offset into record mismatch
      push_pair(1, 1, t0, 64'h4000, 100, 32'h2, 1, d0, 64'h4000, 100, 0);
      push_pair(1, 1, t0, 64'h4000, 100, 0, 1, d0, 64'h4001, 100, 0);
      push_pair(1, 1, t0 - 4, 64'h4000, 104, 0, 1, d0 - 8, 64'h4000, 108, 0);
      // uneven remainders short of the range, then covering it
      push_pair(1, 1, t0, 64'h4000, 30, 0, 1, d0, 64'h4000, 40, 0);
      push_pair(1, 1, t0, 64'h4000, 100, 0, 1, d0, 64'h4000, 150, 0);
      // flag outside the mask
      push_pair(1, 1, t0, 64'h4000, 100, 32'h8, 1, d0, 64'h4000, 100, 32'h8);
      drain_pipeline();

      // Extreme registers: offsets at the wrap point, full range, empty mask.
      write_config(ALL_ONES, 64'd0, ALL_ONES, 32'h0);
      push_pair(1, 1, ALL_ONES, ALL_ONES, ALL_ONES, '1, 1, ALL_ONES, ALL_ONES, ALL_ONES, '1);
      push_pair(1, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0);
      push_pair(1, 1, ALL_ONES, 64'h1234, ALL_ONES, '1, 1, 64'd0, 64'h1234, ALL_ONES, '1);
      push_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      drain_pipeline();

      // Random phases, each under its own register setting; the last one runs
      // with no idling on either side.
      for (p = 0; p < 8; p++) begin
         case (p)
            0: write_config(rand_below(64'd1 << 20), rand_below(64'd1 << 20),
                            1 + rand_below(64'd4096), NO_ADDRESS_MASK_RESET);
            1: write_config(rand64(), rand64(), rand64(), $urandom);
            2: write_config(ALL_ONES, ALL_ONES - 5, 64'd1, 32'h0);
            3: write_config(64'd0, rand64(), ALL_ONES, 32'hFFFF_FFFF);
            4: write_config(rand64(), rand64(), 1 + rand_below(64'd1 << 20),
                            NO_ADDRESS_MASK_RESET);
            5: write_config(rand64(), rand64(), 64'd0, $urandom);
            6: write_config(rand_below(64'd1 << 32), rand64(),
                            rand64() >> $urandom_range(0, 63), NO_ADDRESS_MASK_RESET);
            default: write_config(rand64(), rand64(), 1 + rand_below(64'd1 << 16),
                                  NO_ADDRESS_MASK_RESET);
         endcase
         if (p == 7) steady_phase = 1'b1;
         quota = (p == 5) ? 40 : 150;
         count = 0;
         while (count < quota) begin
            if ($urandom_range(0, 6) == 0) begin
               pending_pairs.push_back(noise_pair($urandom_range(0, 1)));
               count++;
            end else begin
               count += queue_comparison();
            end
            // stray transactions after the decision, which the block only echoes
            if ($urandom_range(0, 3) == 0) pending_pairs.push_back(noise_pair(1'b0));
         end
         drain_pipeline();
      end

      repeat (20) @(posedge clock);
      if (expected_decisions.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_decisions.size()));

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
